// ===== hw/rtl/rse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants of the RPN stack evaluator
// Widths, status and operator codes, state encodings and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package rse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int DEPTH_W     = 5;
	localparam int STATUS_W    = 3;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int QUO_BITS    = DATA_W;
	localparam int CNT_W       = $clog2(QUO_BITS);

	localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic {
		OP_PUSH,
		OP_APPLY
	} operation_t;

	typedef enum logic [1:0] {
		OPC_ADD,
		OPC_SUB,
		OPC_MUL,
		OPC_DIV
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		RES_ADD,
		RES_SUB,
		RES_MUL,
		RES_DIV,
		RES_DIVZ
	} res_sel_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DECODE,
		CS_FETCH,
		CS_MUL,
		CS_DIV,
		CS_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_PREP,
		DIV_ITER,
		DIV_DONE
	} div_state_t;

	// controller -> datapath
	typedef struct packed {
		logic     tok_load;
		logic     push;
		logic     flag;
		status_t  flag_code;
		logic     rd_left;
		logic     mul_load;
		logic     div_start;
		logic     commit;
		res_sel_t commit_sel;
		logic     out_load;
	} rse_cmd_t;

	// datapath -> controller
	typedef struct packed {
		operation_t op;
		opcode_t    code;
		logic       full;
		logic       short_stack;
		logic       right_zero;
		logic       div_done;
		logic       out_free;
	} rse_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rse_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_if: token and result channels
// Valid/ready channels carrying one token in and one result out.
// ----------------------------------------------------------------------------
interface rse_token_if import rse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic [1:0]               operator_code;
	logic signed [DATA_W-1:0] number_value;

	modport source (output valid, output operation, output operator_code,
		output number_value, input ready);
	modport sink (input valid, input operation, input operator_code,
		input number_value, output ready);
endinterface

interface rse_result_if import rse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic [DEPTH_W-1:0]       stack_depth;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, output top_value, output stack_depth,
		output status, input ready);
	modport sink (input valid, input top_value, input stack_depth,
		input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rse_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rse_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rse_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_divider: iterative fixed-point divider
// Restoring radix-2 division of (a * 2^FRAC_BITS) by b, one quotient bit
// per cycle, truncated toward zero and saturated to the signed range.
// ----------------------------------------------------------------------------
module rse_divider import rse_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                   done,
	output logic      [DATA_W-1:0] quotient,
	output logic                   saturated
);

	div_state_t          state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [DATA_W-1:0]   ua_q, ub_q, rem_q, quo_q;
	logic                neg_q, ovf_q;

	logic [DATA_W-1:0]   a_abs, b_abs;
	logic [2*DATA_W-1:0] num_w;
	logic [DATA_W-1:0]   hi_w, lo_w;
	logic                big_w;
	logic [DATA_W:0]     trial_w;
	logic [DATA_W+1:0]   diff_w;
	logic                ge_w;

	assign a_abs = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
	assign b_abs = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;

	// quotient needs more than DATA_W bits exactly when hi >= divisor
	assign num_w = {{DATA_W{1'b0}}, ua_q} << FRAC_BITS;
	assign hi_w  = num_w[2*DATA_W-1:DATA_W];
	assign lo_w  = num_w[DATA_W-1:0];
	assign big_w = (hi_w >= ub_q);

	assign trial_w = {rem_q, quo_q[DATA_W-1]};
	assign diff_w  = {1'b0, trial_w} - {2'b00, ub_q};
	assign ge_w    = ~diff_w[DATA_W+1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					state_d = DIV_PREP;
				end
			end
			DIV_PREP: begin
				state_d = big_w ? DIV_DONE : DIV_ITER;
			end
			DIV_ITER: begin
				if (cnt_q == CNT_W'(QUO_BITS - 1)) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: begin
				state_d = DIV_IDLE;
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	always_comb begin
		done      = (state_q == DIV_DONE);
		saturated = 1'b0;
		quotient  = quo_q;
		if (ovf_q) begin
			saturated = 1'b1;
			quotient  = neg_q ? VAL_MIN : VAL_MAX;
		end else if (neg_q) begin
			if (quo_q > VAL_MIN) begin
				saturated = 1'b1;
				quotient  = VAL_MIN;
			end else begin
				quotient = DATA_W'(0) - quo_q;
			end
		end else if (quo_q[DATA_W-1]) begin
			saturated = 1'b1;
			quotient  = VAL_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DIV_ITER) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					ua_q  <= a_abs;
					ub_q  <= b_abs;
					neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
				end
			end
			DIV_PREP: begin
				ovf_q <= big_w;
				rem_q <= hi_w;
				quo_q <= lo_w;
			end
			DIV_ITER: begin
				rem_q <= ge_w ? diff_w[DATA_W-1:0] : trial_w[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], ge_w};
			end
			default: begin
				ovf_q <= ovf_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rse_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_datapath: operand stack and arithmetic
// Top-of-stack register, stack RAM below it, add/sub/mul/div units and
// the result output register.
// ----------------------------------------------------------------------------
module rse_datapath import rse_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tok_operation,
	input  wire logic [1:0]          tok_operator_code,
	input  wire logic [DATA_W-1:0]   tok_number_value,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic [DATA_W-1:0]        out_top_value,
	output logic [DEPTH_W-1:0]       out_stack_depth,
	output logic [STATUS_W-1:0]      out_status,
	input  wire rse_cmd_t            cmd,
	output rse_stat_t                stat
);

	logic                       tok_op_q;
	logic [1:0]                 tok_code_q;
	logic [DATA_W-1:0]          tok_val_q;
	logic [DATA_W-1:0]          tos_q;
	logic [SP_W-1:0]            sp_q;
	status_t                    stat_q;
	logic signed [2*DATA_W-1:0] prod_q;

	logic                       out_valid_q;
	logic [DATA_W-1:0]          out_top_q;
	logic [DEPTH_W-1:0]         out_depth_q;
	logic [STATUS_W-1:0]        out_status_q;

	logic [SP_W-1:0]            sp_m1, sp_m2;
	logic [DATA_W-1:0]          left_w;
	logic [DATA_W:0]            sum_w, dif_w;
	logic signed [2*DATA_W-1:0] shr_w;
	logic                       div_done_w, div_sat_w;
	logic [DATA_W-1:0]          div_q_w;
	logic [DATA_W-1:0]          res_val;
	status_t                    res_st;

	assign sp_m1 = sp_q - SP_W'(1);
	assign sp_m2 = sp_q - SP_W'(2);

	rse_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (cmd.push && (sp_q != '0)),
		.waddr (sp_m1[ADDR_W-1:0]),
		.wdata (tos_q),
		.re    (cmd.rd_left),
		.raddr (sp_m2[ADDR_W-1:0]),
		.rdata (left_w)
	);

	rse_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (left_w),
		.divisor   (tos_q),
		.done      (div_done_w),
		.quotient  (div_q_w),
		.saturated (div_sat_w)
	);

	assign sum_w = {left_w[DATA_W-1], left_w} + {tos_q[DATA_W-1], tos_q};
	assign dif_w = {left_w[DATA_W-1], left_w} - {tos_q[DATA_W-1], tos_q};
	assign shr_w = prod_q >>> FRAC_BITS;

	always_comb begin
		res_val = '0;
		res_st  = ST_OK;
		case (cmd.commit_sel)
			RES_ADD: begin
				if (sum_w[DATA_W] != sum_w[DATA_W-1]) begin
					res_val = sum_w[DATA_W] ? VAL_MIN : VAL_MAX;
					res_st  = ST_SATURATED;
				end else begin
					res_val = sum_w[DATA_W-1:0];
				end
			end
			RES_SUB: begin
				if (dif_w[DATA_W] != dif_w[DATA_W-1]) begin
					res_val = dif_w[DATA_W] ? VAL_MIN : VAL_MAX;
					res_st  = ST_SATURATED;
				end else begin
					res_val = dif_w[DATA_W-1:0];
				end
			end
			RES_MUL: begin
				if ((&shr_w[2*DATA_W-1:DATA_W-1]) || !(|shr_w[2*DATA_W-1:DATA_W-1])) begin
					res_val = shr_w[DATA_W-1:0];
				end else begin
					res_val = shr_w[2*DATA_W-1] ? VAL_MIN : VAL_MAX;
					res_st  = ST_SATURATED;
				end
			end
			RES_DIV: begin
				res_val = div_q_w;
				res_st  = div_sat_w ? ST_SATURATED : ST_OK;
			end
			RES_DIVZ: begin
				res_val = left_w[DATA_W-1] ? VAL_MIN : VAL_MAX;
				res_st  = ST_DIVZERO;
			end
			default: begin
				res_val = '0;
				res_st  = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				sp_q <= sp_q + SP_W'(1);
			end else if (cmd.commit) begin
				sp_q <= sp_m1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tok_load) begin
			tok_op_q   <= tok_operation;
			tok_code_q <= tok_operator_code;
			tok_val_q  <= tok_number_value;
		end
		if (cmd.push) begin
			tos_q  <= tok_val_q;
			stat_q <= ST_OK;
		end else if (cmd.commit) begin
			tos_q  <= res_val;
			stat_q <= res_st;
		end else if (cmd.flag) begin
			stat_q <= cmd.flag_code;
		end
		if (cmd.mul_load) begin
			prod_q <= $signed(left_w) * $signed(tos_q);
		end
		if (cmd.out_load) begin
			out_top_q    <= (sp_q != '0) ? tos_q : '0;
			out_depth_q  <= DEPTH_W'(sp_q);
			out_status_q <= stat_q;
		end
	end

	assign stat.op          = operation_t'(tok_op_q);
	assign stat.code        = opcode_t'(tok_code_q);
	assign stat.full        = (sp_q >= SP_W'(STACK_DEPTH));
	assign stat.short_stack = (sp_q < SP_W'(2));
	assign stat.right_zero  = (tos_q == '0);
	assign stat.div_done    = div_done_w;
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_top_value   = out_top_q;
	assign out_stack_depth = out_depth_q;
	assign out_status      = out_status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ctrl: token sequencer
// Steps one token through decode, operand fetch, arithmetic and result
// hand-off by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module rse_ctrl import rse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      tok_valid,
	output logic           tok_ready,
	input  wire rse_stat_t stat,
	output rse_cmd_t       cmd
);

	ctl_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (tok_valid) begin
					state_d = CS_DECODE;
				end
			end
			CS_DECODE: begin
				if (stat.op == OP_PUSH || stat.short_stack) begin
					state_d = CS_DONE;
				end else begin
					state_d = CS_FETCH;
				end
			end
			CS_FETCH: begin
				case (stat.code)
					OPC_MUL: state_d = CS_MUL;
					OPC_DIV: state_d = stat.right_zero ? CS_DONE : CS_DIV;
					default: state_d = CS_DONE;
				endcase
			end
			CS_MUL: begin
				state_d = CS_DONE;
			end
			CS_DIV: begin
				if (stat.div_done) begin
					state_d = CS_DONE;
				end
			end
			CS_DONE: begin
				if (stat.out_free) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.flag_code  = ST_OK;
		cmd.commit_sel = RES_ADD;
		tok_ready      = (state_q == CS_IDLE);
		case (state_q)
			CS_IDLE: begin
				cmd.tok_load = tok_valid;
			end
			CS_DECODE: begin
				if (stat.op == OP_PUSH) begin
					if (stat.full) begin
						cmd.flag      = 1'b1;
						cmd.flag_code = ST_OVERFLOW;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (stat.short_stack) begin
					cmd.flag      = 1'b1;
					cmd.flag_code = ST_UNDERFLOW;
				end else begin
					cmd.rd_left = 1'b1;
				end
			end
			CS_FETCH: begin
				case (stat.code)
					OPC_ADD: begin
						cmd.commit     = 1'b1;
						cmd.commit_sel = RES_ADD;
					end
					OPC_SUB: begin
						cmd.commit     = 1'b1;
						cmd.commit_sel = RES_SUB;
					end
					OPC_MUL: begin
						cmd.mul_load = 1'b1;
					end
					OPC_DIV: begin
						if (stat.right_zero) begin
							cmd.commit     = 1'b1;
							cmd.commit_sel = RES_DIVZ;
						end else begin
							cmd.div_start = 1'b1;
						end
					end
					default: begin
						cmd.commit = 1'b0;
					end
				endcase
			end
			CS_MUL: begin
				cmd.commit     = 1'b1;
				cmd.commit_sel = RES_MUL;
			end
			CS_DIV: begin
				cmd.commit     = stat.div_done;
				cmd.commit_sel = RES_DIV;
			end
			CS_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd.out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rpn_stack_evaluator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core: postfix evaluator on a Q16.16 operand stack
// Top level joining the token sequencer and the stack datapath.
// ----------------------------------------------------------------------------
// One token item is taken at a time and answered by exactly one result item
// carrying the top of stack (0 when empty), the depth and a status code.
// A number token is pushed; an operator token pops two operands (the lower
// is the left operand) and pushes the sum, difference, product or quotient,
// saturated to the signed 32-bit range; a push onto a full stack or an
// operator on fewer than two operands is rejected. The next token is taken
// once the last result has entered the output register. Multiply uses one
// registered 32x32 multiplier, divide the radix-2 divider that produces one
// of 32 quotient bits per cycle; a divide by zero bypasses the divider and an
// overflowing quotient skips its bit iterations. The top of stack lives in a
// register and the entries below it in a single-port-read RAM, so an operator
// fetches its left operand before the arithmetic. A finished result waits in
// the output register while the next item is accepted. No clearing pass
// follows reset: the stack pointer alone marks which entries are live.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core import rse_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rse_token_if.sink   token,
	rse_result_if.source result
);

	rse_cmd_t  cmd;
	rse_stat_t stat;

	// sequencer: one token in flight, accepts only when idle
	rse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (token.valid),
		.tok_ready (token.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// stack, arithmetic units and the output register
	rse_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.tok_operation     (token.operation),
		.tok_operator_code (token.operator_code),
		.tok_number_value  (token.number_value),
		.out_ready         (result.ready),
		.out_valid         (result.valid),
		.out_top_value     (result.top_value),
		.out_stack_depth   (result.stack_depth),
		.out_status        (result.status),
		.cmd               (cmd),
		.stat              (stat)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/rse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_checker: port-level checks of the evaluator
// Result hold under stall and consistency of depth, top and status.
// ----------------------------------------------------------------------------
module rse_checker import rse_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire logic [DATA_W-1:0]   res_top_value,
	input wire logic [DEPTH_W-1:0]  res_stack_depth,
	input wire logic [STATUS_W-1:0] res_status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_top_value)
			&& $stable(res_stack_depth) && $stable(res_status))
		else $error("result item changed while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_stack_depth <= DEPTH_W'(STACK_DEPTH))
		else $error("reported depth beyond stack size");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stack_depth == '0 |-> res_top_value == '0)
		else $error("empty stack with non-zero top");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_W'(ST_OVERFLOW)
			|-> res_stack_depth == DEPTH_W'(STACK_DEPTH))
		else $error("overflow reported on a stack that is not full");

	a_unf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_W'(ST_UNDERFLOW)
			|-> res_stack_depth < DEPTH_W'(2))
		else $error("underflow reported with two or more operands");

endmodule

bind rpn_stack_evaluator_core rse_checker u_rse_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_top_value   (result.top_value),
	.res_stack_depth (result.stack_depth),
	.res_status      (result.status)
);
`default_nettype wire
